// ===== rtl/core/madt_pkg.sv =====
`default_nettype none
package madt_pkg;

  localparam int DEF_MAX_CPUS = 64;
  localparam int COUNT_W      = 7;
  localparam int APB_ADDR_W   = 3;
  localparam int APB_DATA_W   = 32;

  localparam logic [COUNT_W-1:0] CPU_LIMIT_RESET = 7'd64;

  localparam logic [7:0] TYPE_LAPIC     = 8'd0;
  localparam logic [7:0] TYPE_X2APIC    = 8'd9;
  localparam logic [7:0] MIN_ENTRY_LEN  = 8'd2;
  localparam logic [7:0] LAPIC_MIN_LEN  = 8'd8;
  localparam logic [7:0] X2APIC_MIN_LEN = 8'd16;
  localparam logic [7:0] BAD_XAPIC_ID   = 8'hff;
  localparam logic [31:0] BAD_X2APIC_ID = 32'hffff_ffff;

  typedef enum logic [0:0] {
    REG_CPU_LIMIT = 1'b0,
    REG_NONE      = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_SKIPPED   = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_MALFORMED = 3'd3,
    ST_CONFLICT  = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  typedef enum logic [0:0] {
    KIND_LAPIC  = 1'b0,
    KIND_X2APIC = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [7:0]  entry_type;
    logic [7:0]  entry_length;
    logic [7:0]  bytes_available;
    logic [7:0]  byte_two;
    logic [7:0]  byte_three;
    logic [31:0] word_four;
    logic [31:0] word_eight;
    logic [31:0] word_twelve;
  } madt_in_t;

  typedef struct packed {
    status_t             status;
    logic [31:0]         cpu_apic_id;
    logic [31:0]         cpu_uid;
    logic                source_kind;
    logic [COUNT_W-1:0]  cpu_count;
  } madt_out_t;

  typedef struct packed {
    logic    accept;
    logic    step;
    logic    commit;
    logic    set_status;
    status_t code;
    logic    load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic dec_ok;
    logic over_limit;
    logic at_limit;
    logic empty;
    logic hit_dup;
    logic hit_conf;
    logic scan_last;
    logic out_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/madt_ctrl.sv =====
`default_nettype none
module madt_ctrl
  import madt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire dp_stat_t  stat,
  output ctrl_cmd_t      cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!stat.dec_ok || stat.over_limit || stat.empty) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.hit_dup || stat.hit_conf || stat.scan_last) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!stat.out_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.code = ST_ADDED;
    in_stall = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      S_CHECK: begin
        if (!stat.dec_ok) begin
          cmd.set_status = 1'b0;
        end else if (stat.over_limit) begin
          cmd.set_status = 1'b1;
          cmd.code       = ST_FULL;
        end else if (stat.empty) begin
          if (stat.at_limit) begin
            cmd.set_status = 1'b1;
            cmd.code       = ST_FULL;
          end else begin
            cmd.commit = 1'b1;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_SCAN: begin
        if (stat.hit_dup) begin
          cmd.set_status = 1'b1;
          cmd.code       = ST_DUPLICATE;
        end else if (stat.hit_conf) begin
          cmd.set_status = 1'b1;
          cmd.code       = ST_CONFLICT;
        end else if (stat.scan_last) begin
          if (stat.at_limit) begin
            cmd.set_status = 1'b1;
            cmd.code       = ST_FULL;
          end else begin
            cmd.commit = 1'b1;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_FINISH: begin
        cmd.load_out = !stat.out_busy;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !stat.empty)
    else $error("table scan entered with an empty table");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (state_r == S_CHECK))
    else $error("accepted request did not move to the check step");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> (state_r == S_IDLE))
    else $error("controller did not return to idle after loading a result");

endmodule
`default_nettype wire

// ===== rtl/core/madt_dp.sv =====
`default_nettype none
module madt_dp
  import madt_pkg::*;
#(
  parameter int MAX_CPUS = DEF_MAX_CPUS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire madt_in_t           in_req,
  input  wire logic [COUNT_W-1:0] cpu_limit,
  input  wire ctrl_cmd_t          cmd,
  output dp_stat_t                stat,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output madt_out_t               out_rsp
);

  localparam int IDX_W = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
  localparam int AW    = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;
  localparam int MW    = $clog2(MAX_CPUS + 1);
  localparam int LW    = (MW > COUNT_W) ? MW : COUNT_W;

  status_t             dec_status;
  logic [31:0]         dec_apic;
  logic [31:0]         dec_uid;
  kind_t               dec_kind;
  logic                len_bad;

  status_t             dec_status_r;
  logic [31:0]         apic_r;
  logic [31:0]         uid_r;
  kind_t               kind_r;
  status_t             res_status_r;
  logic [COUNT_W-1:0]  scan_idx_r;
  logic [COUNT_W-1:0]  count_r;
  logic [63:0]         pair_mem_r [MAX_CPUS];
  logic [63:0]         rd_data_r;
  madt_out_t           out_r;
  logic                out_valid_r;

  logic [AW-1:0]       rd_addr_ext;
  logic [AW-1:0]       wr_addr_ext;
  logic [IDX_W-1:0]    rd_addr;
  logic [IDX_W-1:0]    wr_addr;
  logic [LW-1:0]       lim_ext;
  logic [LW-1:0]       max_ext;
  logic [LW-1:0]       eff_limit;
  logic [LW-1:0]       count_ext;

  assign len_bad = (in_req.bytes_available < MIN_ENTRY_LEN) ||
                   (in_req.entry_length < MIN_ENTRY_LEN) ||
                   (in_req.entry_length > in_req.bytes_available);

  always_comb begin
    dec_status = ST_SKIPPED;
    dec_apic   = '0;
    dec_uid    = '0;
    dec_kind   = KIND_LAPIC;
    if (len_bad) begin
      dec_status = ST_MALFORMED;
    end else if (in_req.entry_type == TYPE_LAPIC) begin
      if (in_req.entry_length < LAPIC_MIN_LEN) begin
        dec_status = ST_MALFORMED;
      end else if (!in_req.word_four[0]) begin
        dec_status = ST_SKIPPED;
      end else if (in_req.byte_three == BAD_XAPIC_ID) begin
        dec_status = ST_MALFORMED;
      end else begin
        dec_status = ST_ADDED;
        dec_apic   = {24'd0, in_req.byte_three};
        dec_uid    = {24'd0, in_req.byte_two};
        dec_kind   = KIND_LAPIC;
      end
    end else if (in_req.entry_type == TYPE_X2APIC) begin
      if ((in_req.entry_length < X2APIC_MIN_LEN) || (in_req.byte_two != 8'd0) ||
          (in_req.byte_three != 8'd0)) begin
        dec_status = ST_MALFORMED;
      end else if (!in_req.word_eight[0]) begin
        dec_status = ST_SKIPPED;
      end else if (in_req.word_four == BAD_X2APIC_ID) begin
        dec_status = ST_MALFORMED;
      end else begin
        dec_status = ST_ADDED;
        dec_apic   = in_req.word_four;
        dec_uid    = in_req.word_twelve;
        dec_kind   = KIND_X2APIC;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dec_status_r <= dec_status;
      apic_r       <= dec_apic;
      uid_r        <= dec_uid;
      kind_r       <= dec_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_status_r <= dec_status;
    end else if (cmd.set_status) begin
      res_status_r <= cmd.code;
    end else if (cmd.commit) begin
      res_status_r <= ST_ADDED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      count_r    <= '0;
    end else begin
      if (cmd.accept) begin
        scan_idx_r <= '0;
      end else if (cmd.step) begin
        scan_idx_r <= scan_idx_r + 1'b1;
      end
      if (cmd.commit) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  assign rd_addr_ext = AW'(scan_idx_r);
  assign wr_addr_ext = AW'(count_r);
  assign rd_addr     = rd_addr_ext[IDX_W-1:0];
  assign wr_addr     = wr_addr_ext[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      pair_mem_r[wr_addr] <= {apic_r, uid_r};
    end
    rd_data_r <= pair_mem_r[rd_addr];
  end

  assign lim_ext   = LW'(cpu_limit);
  assign max_ext   = LW'(MAX_CPUS);
  assign eff_limit = (lim_ext > max_ext) ? max_ext : lim_ext;
  assign count_ext = LW'(count_r);

  always_comb begin
    stat            = '0;
    stat.dec_ok     = (dec_status_r == ST_ADDED);
    stat.over_limit = (count_ext > eff_limit);
    stat.at_limit   = (count_ext >= eff_limit);
    stat.empty      = (count_r == '0);
    stat.hit_dup    = (rd_data_r[63:32] == apic_r) && (rd_data_r[31:0] == uid_r);
    stat.hit_conf   = (rd_data_r[63:32] == apic_r) || (rd_data_r[31:0] == uid_r);
    stat.scan_last  = (scan_idx_r == count_r);
    stat.out_busy   = out_valid_r && out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.status      <= res_status_r;
      out_r.cpu_apic_id <= apic_r;
      out_r.cpu_uid     <= uid_r;
      out_r.source_kind <= kind_r;
      out_r.cpu_count   <= count_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !stat.at_limit)
    else $error("pair stored beyond the effective table limit");

  assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.commit |=> $stable(count_r))
    else $error("CPU count changed without a store");

  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.load_out))
    else $error("result appeared without a load");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !stat.out_busy)
    else $error("result loaded over one that is still waiting");

endmodule
`default_nettype wire

// ===== rtl/core/madt_cpu_entry_register.sv =====
`default_nettype none
// Decodes one ACPI MADT local APIC or x2APIC entry per request and adds the
// online CPU it describes to an on-chip table of (APIC id, ACPI uid) pairs,
// returning one result per request with the status, the decoded ids and the
// CPU count. Every insert scans the stored pairs one per cycle through the
// single read port of the pair memory, so a request takes longer as the table
// fills. A skipped, malformed or over-limit entry does not scan. The
// cpu_limit register at byte address 0 caps the table, and a value above
// MAX_CPUS acts as MAX_CPUS. The table needs no clearing after reset.
module madt_cpu_entry_register
  import madt_pkg::*;
#(
  parameter int MAX_CPUS = DEF_MAX_CPUS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire madt_in_t              in_req,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output madt_out_t                  out_rsp,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready
);

  logic [COUNT_W-1:0] cpu_limit_r;
  reg_idx_t           reg_idx;
  logic               cfg_write;
  ctrl_cmd_t          cmd;
  dp_stat_t           stat;

  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpu_limit_r <= CPU_LIMIT_RESET;
    end else if (cfg_write && (reg_idx == REG_CPU_LIMIT)) begin
      cpu_limit_r <= pwdata[COUNT_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CPU_LIMIT: prdata = APB_DATA_W'(cpu_limit_r);
      default:       prdata = '0;
    endcase
  end

  madt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  madt_dp #(
    .MAX_CPUS (MAX_CPUS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cpu_limit (cpu_limit_r),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp)
  );

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import madt_pkg::*;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int SETTLE_CYCLES   = 70;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  madt_in_t              in_req    = '0;
  logic                  out_stall = 1'b0;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [APB_ADDR_W-1:0] paddr     = '0;
  logic [APB_DATA_W-1:0] pwdata    = '0;
  logic                  in_stall;
  logic                  out_valid;
  madt_out_t             out_rsp;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  madt_cpu_entry_register #(.MAX_CPUS(DEF_MAX_CPUS)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  madt_in_t     pending_entries[$];
  madt_out_t    expected_rsp[$];
  logic [31:0]  table_apic[DEF_MAX_CPUS];
  logic [31:0]  table_uid[DEF_MAX_CPUS];
  int           table_fill    = 0;
  logic [6:0]   limit_shadow  = CPU_LIMIT_RESET;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           errors        = 0;
  int           entries_sent  = 0;
  int           results_seen  = 0;
  int           outcome_tally[6];

  initial begin
    forever #1 clk = ~clk;
  end

  // Decodes one entry and applies it to the shadow CPU table.
  function automatic madt_out_t register_entry(madt_in_t e);
    madt_out_t r;
    int        eff_limit;
    int        i;
    bit        hit;
    r = '0;
    r.status = ST_ADDED;
    if (e.bytes_available < MIN_ENTRY_LEN || e.entry_length < MIN_ENTRY_LEN ||
        e.entry_length > e.bytes_available) begin
      r.status = ST_MALFORMED;
    end else if (e.entry_type == TYPE_LAPIC) begin
      if (e.entry_length < LAPIC_MIN_LEN) r.status = ST_MALFORMED;
      else if (!e.word_four[0]) r.status = ST_SKIPPED;
      else if (e.byte_three == BAD_XAPIC_ID) r.status = ST_MALFORMED;
      else begin
        r.cpu_apic_id = {24'd0, e.byte_three};
        r.cpu_uid     = {24'd0, e.byte_two};
        r.source_kind = KIND_LAPIC;
      end
    end else if (e.entry_type == TYPE_X2APIC) begin
      if (e.entry_length < X2APIC_MIN_LEN || e.byte_two != 8'd0 || e.byte_three != 8'd0)
        r.status = ST_MALFORMED;
      else if (!e.word_eight[0]) r.status = ST_SKIPPED;
      else if (e.word_four == BAD_X2APIC_ID) r.status = ST_MALFORMED;
      else begin
        r.cpu_apic_id = e.word_four;
        r.cpu_uid     = e.word_twelve;
        r.source_kind = KIND_X2APIC;
      end
    end else begin
      r.status = ST_SKIPPED;
    end
    if (r.status == ST_ADDED) begin
      eff_limit = (limit_shadow > DEF_MAX_CPUS) ? DEF_MAX_CPUS : int'(limit_shadow);
      if (table_fill > eff_limit) begin
        r.status = ST_FULL;
      end else begin
        hit = 1'b0;
        for (i = 0; i < table_fill && !hit; i++) begin
          if (table_apic[i] == r.cpu_apic_id && table_uid[i] == r.cpu_uid) begin
            r.status = ST_DUPLICATE;
            hit = 1'b1;
          end else if (table_apic[i] == r.cpu_apic_id || table_uid[i] == r.cpu_uid) begin
            r.status = ST_CONFLICT;
            hit = 1'b1;
          end
        end
        if (!hit) begin
          if (table_fill >= eff_limit) begin
            r.status = ST_FULL;
          end else begin
            table_apic[table_fill] = r.cpu_apic_id;
            table_uid[table_fill]  = r.cpu_uid;
            table_fill++;
          end
        end
      end
    end
    r.cpu_count = 7'(table_fill);
    outcome_tally[int'(r.status)]++;
    return r;
  endfunction

  function automatic madt_in_t make_entry(logic [7:0] etype, logic [7:0] len,
                                          logic [7:0] avail, logic [7:0] b2,
                                          logic [7:0] b3, logic [31:0] w4,
                                          logic [31:0] w8, logic [31:0] w12);
    madt_in_t e;
    e.entry_type      = etype;
    e.entry_length    = len;
    e.bytes_available = avail;
    e.byte_two        = b2;
    e.byte_three      = b3;
    e.word_four       = w4;
    e.word_eight      = w8;
    e.word_twelve     = w12;
    return e;
  endfunction

  // Mostly well-formed CPU entries whose ids often repeat or clash with the
  // table contents, plus a share of arbitrary and broken entries.
  function automatic madt_in_t random_entry();
    madt_in_t    e;
    int          pick;
    int          slot;
    logic [31:0] apic;
    logic [31:0] uid;
    pick = $urandom_range(99);
    e = make_entry(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom), $urandom, $urandom, $urandom);
    if (pick < 20) begin
      if (pick < 12) e.entry_type = $urandom_range(1) ? TYPE_LAPIC : TYPE_X2APIC;
      return e;
    end
    apic = $urandom;
    uid  = $urandom;
    if (pick < 35) begin
      apic = $urandom_range(15);
      uid  = $urandom_range(15);
    end else if (pick >= 55 && table_fill > 0) begin
      slot = $urandom_range(table_fill - 1);
      apic = table_apic[slot];
      uid  = table_uid[slot];
      if (pick >= 75) begin
        if ($urandom_range(1)) apic = $urandom_range(255);
        else uid = $urandom_range(255);
      end
    end else if ($urandom_range(1)) begin
      apic = $urandom_range(254);
      uid  = $urandom_range(255);
    end
    if (apic < 255 && uid < 256 && $urandom_range(1)) begin
      e.entry_type   = TYPE_LAPIC;
      e.entry_length = 8'($urandom_range(8, 40));
      e.byte_two     = uid[7:0];
      e.byte_three   = apic[7:0];
      e.word_four[0] = 1'b1;
    end else begin
      e.entry_type    = TYPE_X2APIC;
      e.entry_length  = 8'($urandom_range(16, 60));
      e.byte_two      = 8'd0;
      e.byte_three    = 8'd0;
      e.word_four     = apic;
      e.word_eight[0] = 1'b1;
      e.word_twelve   = uid;
    end
    e.bytes_available = 8'($urandom_range(e.entry_length, 255));
    return e;
  endfunction

  task automatic queue_entry(input madt_in_t e);
    pending_entries.push_back(e);
    entries_sent++;
  endtask

  task automatic feed_random(input int count);
    repeat (count) begin
      while (pending_entries.size() >= 4) @(posedge clk);
      queue_entry(random_entry());
    end
  endtask

  task automatic quiesce();
    while (results_seen != entries_sent) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_cpu_limit(input logic [6:0] value);
    quiesce();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(4 * int'(REG_CPU_LIMIT));
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    limit_shadow = value;
  endtask

  function automatic void check_field(string what, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      errors++;
      $display("%0t: %s expected 0x%0h got 0x%0h", $time, what, want_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_rsp.push_back(register_entry(in_req));
      if (!in_valid || !in_stall) begin
        if (pending_entries.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_req   <= pending_entries.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    madt_out_t want;
    out_stall <= ($urandom_range(99) < recv_idle_pct);
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_rsp.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none got %p", $time, out_rsp);
      end else begin
        want = expected_rsp.pop_front();
        check_field("status", 32'(want.status), 32'(out_rsp.status));
        check_field("cpu_apic_id", want.cpu_apic_id, out_rsp.cpu_apic_id);
        check_field("cpu_uid", want.cpu_uid, out_rsp.cpu_uid);
        check_field("source_kind", 32'(want.source_kind), 32'(out_rsp.source_kind));
        check_field("cpu_count", 32'(want.cpu_count), 32'(out_rsp.cpu_count));
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("madt_cpu_entry_register: mismatch");
    $finish;
  end

  initial begin
    send_idle_pct = 30;
    recv_idle_pct = 72;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    set_cpu_limit(7'd0);
    queue_entry(make_entry(TYPE_LAPIC, 8, 8, 8'd1, 8'd2, 32'h1, 32'h0, 32'h0));

    set_cpu_limit(7'd3);
    queue_entry(make_entry(8'd5, 0, 0, 8'd0, 8'd0, 32'h0, 32'h0, 32'h0));
    queue_entry(make_entry(TYPE_LAPIC, 1, 255, 8'd3, 8'd3, 32'h1, 32'h0, 32'h0));
    queue_entry(make_entry(TYPE_X2APIC, 20, 19, 8'd0, 8'd0, 32'h5, 32'h1, 32'h5));
    queue_entry(make_entry(TYPE_LAPIC, 7, 255, 8'd3, 8'd3, 32'h1, 32'h0, 32'h0));
    queue_entry(make_entry(TYPE_LAPIC, 8, 8, 8'd3, 8'hff, 32'hffff_fffe, 32'h0, 32'h0));
    queue_entry(make_entry(TYPE_LAPIC, 8, 8, 8'd3, 8'hff, 32'h1, 32'h0, 32'h0));
    queue_entry(make_entry(TYPE_LAPIC, 255, 255, 8'hff, 8'hfe, 32'hffff_ffff,
                           32'hffff_ffff, 32'hffff_ffff));
    queue_entry(make_entry(TYPE_X2APIC, 15, 16, 8'd0, 8'd0, 32'h1, 32'h1, 32'h1));
    queue_entry(make_entry(TYPE_X2APIC, 16, 16, 8'd1, 8'd0, 32'h1, 32'h1, 32'h1));
    queue_entry(make_entry(TYPE_X2APIC, 16, 16, 8'd0, 8'h80, 32'h1, 32'h1, 32'h1));
    queue_entry(make_entry(TYPE_X2APIC, 16, 16, 8'd0, 8'd0, 32'h1, 32'hffff_fffe, 32'h1));
    queue_entry(make_entry(TYPE_X2APIC, 16, 16, 8'd0, 8'd0, 32'hffff_ffff, 32'h1, 32'h1));
    queue_entry(make_entry(TYPE_X2APIC, 16, 255, 8'd0, 8'd0, 32'h0, 32'h1, 32'h0));
    queue_entry(make_entry(8'hff, 16, 16, 8'd0, 8'd0, 32'h1, 32'h1, 32'h1));
    queue_entry(make_entry(8'd1, 12, 12, 8'd0, 8'd0, 32'h1, 32'h1, 32'h1));
    queue_entry(make_entry(TYPE_X2APIC, 16, 16, 8'd0, 8'd0, 32'hfe, 32'h1, 32'hff));
    queue_entry(make_entry(TYPE_LAPIC, 8, 8, 8'd5, 8'hfe, 32'h1, 32'h0, 32'h0));
    queue_entry(make_entry(TYPE_X2APIC, 16, 16, 8'd0, 8'd0, 32'h1234_5678, 32'h1, 32'h0));
    queue_entry(make_entry(TYPE_X2APIC, 255, 255, 8'd0, 8'd0, 32'hffff_fffe,
                           32'hffff_ffff, 32'hffff_ffff));
    queue_entry(make_entry(TYPE_LAPIC, 8, 8, 8'd7, 8'd7, 32'h1, 32'h0, 32'h0));
    queue_entry(make_entry(TYPE_LAPIC, 8, 8, 8'd0, 8'd0, 32'h1, 32'h0, 32'h0));
    queue_entry(make_entry(TYPE_LAPIC, 8, 8, 8'd9, 8'd0, 32'h1, 32'h0, 32'h0));

    set_cpu_limit(7'd20);
    feed_random(300);
    // A limit below the current count must reject every insert outright.
    set_cpu_limit(7'd5);
    feed_random(150);

    send_idle_pct = 72;
    recv_idle_pct = 30;
    set_cpu_limit(7'd40);
    feed_random(300);
    set_cpu_limit(7'd127);
    feed_random(600);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_cpu_limit(7'd64);
    feed_random(600);

    quiesce();
    $display("Checked %0d results under cpu_limit 0, 3, 20, 5, 40, 127 and 64.",
             results_seen);
    $display("Added %0d, skipped %0d, duplicate %0d, malformed %0d, conflict %0d, full %0d.",
             outcome_tally[0], outcome_tally[1], outcome_tally[2], outcome_tally[3],
             outcome_tally[4], outcome_tally[5]);
    if (errors == 0) begin
      $display("madt_cpu_entry_register: match");
    end else begin
      $display("madt_cpu_entry_register: mismatch");
    end
    $finish;
  end

endmodule

// ===== madt_cpu_entry_register.f =====
rtl/core/madt_pkg.sv
rtl/core/madt_ctrl.sv
rtl/core/madt_dp.sv
rtl/core/madt_cpu_entry_register.sv
tb/tb.sv
